// ===== rtl/hft_pkg.sv =====
// shared types and constants for the huffman tree codec
package hft_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned LWGT_W   = 16;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned LIDX_W   = 3;
  localparam int unsigned CBITS_W  = 7;
  localparam int unsigned CLEN_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WLEN_W   = 6;
  localparam logic [WLEN_W-1:0] WLEN_MAX = 6'd63;

  typedef enum logic [KIND_W-1:0] {
    K_LOAD   = 2'd0,
    K_QUERY  = 2'd1,
    K_DECODE = 2'd2,
    K_END    = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_INSIDE   = 2'd1,
    ST_NO_TREE  = 2'd2,
    ST_RESERVED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_MERGE,
    S_CODE_INIT,
    S_CODE
  } state_e;

  typedef struct packed {
    logic exec;
    logic clear;
    logic scan;
    logic merge;
    logic code_init;
    logic code_step;
    logic code_store;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic load_fill;
    logic scan_last;
    logic merge_last;
    logic code_done;
    logic leaf_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/hft_in_if.sv =====
// input item channel
interface hft_in_if import hft_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [LWGT_W-1:0]   leaf_weight;
  logic [SYM_W-1:0]    leaf_symbol;
  logic [LIDX_W-1:0]   leaf_index;
  logic                code_bit;

  modport source (output valid, kind, leaf_weight, leaf_symbol, leaf_index, code_bit,
                  input ready);
  modport sink   (input valid, kind, leaf_weight, leaf_symbol, leaf_index, code_bit,
                  output ready);
endinterface

// ===== rtl/hft_out_if.sv =====
// result item channel
interface hft_out_if import hft_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CBITS_W-1:0]  code_bits;
  logic [CLEN_W-1:0]   code_length;
  logic [SYM_W-1:0]    decoded_symbol;
  logic                symbol_valid;
  logic [STATUS_W-1:0] status;

  modport source (output valid, code_bits, code_length, decoded_symbol, symbol_valid,
                  status, input ready);
  modport sink   (input valid, code_bits, code_length, decoded_symbol, symbol_valid,
                  status, output ready);
endinterface

// ===== rtl/huffman_tree_codec_top.sv =====
// top level of the static huffman tree codec
//   channel | dir | fields
//   in_i    | in  | kind, leaf_weight, leaf_symbol, leaf_index, code_bit
//   out_o   | out | code_bits, code_length, decoded_symbol, symbol_valid, status
// query, decode, end and non-final load items are taken in the idle state; the result
// is registered and shows the cycle after the item is taken.
// the final load item starts the build: a clear step, then per merge i (LEAVES..2*LEAVES-2)
// a scan over nodes 0..i-1 and a write step, then per leaf an init, a walk up to the root and a store.
// the next item waits while the build runs or while a result is stalled.
// reset is asynchronous, active low, and leaves no tree built.
module huffman_tree_codec_top import hft_pkg::*; #(
  parameter int unsigned LEAVES      = 8,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hft_in_if.sink    in_i,
  hft_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  hft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .kind_i     (kind_e'(in_i.kind)),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hft_dp #(
    .LEAVES      (LEAVES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .kind_i           (kind_e'(in_i.kind)),
    .leaf_weight_i    (in_i.leaf_weight),
    .leaf_symbol_i    (in_i.leaf_symbol),
    .leaf_index_i     (in_i.leaf_index),
    .code_bit_i       (in_i.code_bit),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .code_bits_o      (out_o.code_bits),
    .code_length_o    (out_o.code_length),
    .decoded_symbol_o (out_o.decoded_symbol),
    .symbol_valid_o   (out_o.symbol_valid),
    .status_o         (out_o.status)
  );

endmodule

// ===== rtl/hft_ctrl.sv =====
// sequencer for item handling, tree build and code derivation
module hft_ctrl import hft_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  kind_e kind_i,
  output logic  in_ready_o,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !sts_i.out_busy && kind_i == K_LOAD && sts_i.load_fill) begin
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: state_d = S_SCAN;
      S_SCAN: begin
        if (sts_i.scan_last) state_d = S_MERGE;
      end
      S_MERGE: state_d = sts_i.merge_last ? S_CODE_INIT : S_SCAN;
      S_CODE_INIT: state_d = S_CODE;
      S_CODE: begin
        if (sts_i.code_done) state_d = sts_i.leaf_last ? S_IDLE : S_CODE_INIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = !sts_i.out_busy;
        cmd_o.exec  = in_valid_i && !sts_i.out_busy;
      end
      S_CLEAR:     cmd_o.clear = 1'b1;
      S_SCAN:      cmd_o.scan = 1'b1;
      S_MERGE:     cmd_o.merge = 1'b1;
      S_CODE_INIT: cmd_o.code_init = 1'b1;
      S_CODE: begin
        cmd_o.code_step  = !sts_i.code_done;
        cmd_o.code_store = sts_i.code_done;
        cmd_o.finish     = sts_i.code_done && sts_i.leaf_last;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/hft_dp.sv =====
// node tables, merge search, code walk, decoder and result register
module hft_dp import hft_pkg::*; #(
  parameter int unsigned LEAVES      = 8,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kind_e               kind_i,
  input  logic [LWGT_W-1:0]   leaf_weight_i,
  input  logic [SYM_W-1:0]    leaf_symbol_i,
  input  logic [LIDX_W-1:0]   leaf_index_i,
  input  logic                code_bit_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CBITS_W-1:0]  code_bits_o,
  output logic [CLEN_W-1:0]   code_length_o,
  output logic [SYM_W-1:0]    decoded_symbol_o,
  output logic                symbol_valid_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned NODES = 2 * LEAVES - 1;
  localparam int unsigned IW    = $clog2(NODES);
  localparam int unsigned NW    = $clog2(NODES + 1);
  localparam int unsigned LW    = $clog2(LEAVES);
  localparam int unsigned CW    = $clog2(LEAVES + 1);
  localparam int unsigned WW    = WEIGHT_BITS + $clog2(LEAVES);
  localparam logic [IW-1:0] ROOT  = IW'(NODES - 1);
  localparam logic [WW-1:0] WMASK = {WW{1'b1}} >> (WW - WEIGHT_BITS);

  // children and parents are held as node number plus one, zero means none
  logic [WW-1:0]      weight_q [NODES];
  logic [NW-1:0]      left_q   [NODES];
  logic [NW-1:0]      right_q  [NODES];
  logic [NW-1:0]      parent_q [NODES];
  logic [SYM_W-1:0]   char_q   [LEAVES];
  logic [CBITS_W-1:0] code_q   [LEAVES];
  logic [CLEN_W-1:0]  clen_q   [LEAVES];

  logic [CW-1:0] cnt_q;
  logic          ready_q;
  logic [IW-1:0] walk_q;

  logic [IW-1:0] i_q, j_q, p1_q, p2_q;
  logic [WW-1:0] s1_q, s2_q;
  logic          f1_q, f2_q;

  logic [LW-1:0]      leaf_q;
  logic [NW-1:0]      cc_q, cp_q;
  logic [WLEN_W-1:0]  len_q;
  logic [CBITS_W-1:0] bits_q;

  logic                out_valid_q;
  logic [CBITS_W-1:0]  res_bits_q;
  logic [CLEN_W-1:0]   res_len_q;
  logic [SYM_W-1:0]    res_sym_q;
  logic                res_sv_q;
  logic [STATUS_W-1:0] res_st_q;

  logic [CW-1:0]       cnt_eff;
  logic [WW-1:0]       w_in;
  logic [NW-1:0]       child;
  logic [IW-1:0]       nx;
  logic                leaf_hit;
  logic [SYM_W-1:0]    nx_sym;
  logic [IW-1:0]       cpi;
  logic [WW-1:0]       jw;
  logic                jfree;
  logic [CBITS_W-1:0]  r_bits;
  logic [CLEN_W-1:0]   r_len;
  logic [SYM_W-1:0]    r_sym;
  logic                r_sv;
  status_e             r_st;
  logic [IW-1:0]       walk_next;

  assign cnt_eff  = ready_q ? '0 : cnt_q;
  assign w_in     = WW'(leaf_weight_i) & WMASK;
  assign child    = code_bit_i ? right_q[walk_q] : left_q[walk_q];
  assign nx       = IW'(child - NW'(1));
  assign leaf_hit = (child != '0) && (left_q[nx] == '0);
  assign nx_sym   = (int'(nx) < LEAVES) ? char_q[LW'(nx)] : '0;
  assign cpi      = IW'(cp_q - NW'(1));
  assign jw       = weight_q[j_q];
  assign jfree    = (parent_q[j_q] == '0);

  assign sts_o.load_fill  = (cnt_eff == CW'(LEAVES - 1));
  assign sts_o.scan_last  = (j_q == i_q - IW'(1));
  assign sts_o.merge_last = (i_q == ROOT);
  assign sts_o.code_done  = (cp_q == '0) || (len_q == WLEN_MAX);
  assign sts_o.leaf_last  = (leaf_q == LW'(LEAVES - 1));
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  // result of the item being taken
  always_comb begin
    r_bits    = '0;
    r_len     = '0;
    r_sym     = '0;
    r_sv      = 1'b0;
    r_st      = ST_OK;
    walk_next = walk_q;
    if (kind_i == K_LOAD) begin
      if (ready_q) walk_next = ROOT;
    end else if (!ready_q) begin
      r_st = ST_NO_TREE;
    end else begin
      case (kind_i)
        K_QUERY: begin
          if (int'(leaf_index_i) < LEAVES) begin
            r_bits = code_q[LW'(leaf_index_i)];
            r_len  = clen_q[LW'(leaf_index_i)];
          end
        end
        K_DECODE: begin
          if (child == '0) begin
            walk_next = ROOT;
          end else if (leaf_hit) begin
            r_sym     = nx_sym;
            r_sv      = 1'b1;
            walk_next = ROOT;
          end else begin
            walk_next = nx;
          end
        end
        default: begin
          if (walk_q != ROOT) r_st = ST_INSIDE;
          walk_next = ROOT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ready_q     <= 1'b0;
      walk_q      <= ROOT;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
        walk_q      <= walk_next;
        if (kind_i == K_LOAD) begin
          ready_q <= 1'b0;
          cnt_q   <= cnt_eff + CW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        ready_q <= 1'b1;
        walk_q  <= ROOT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_bits_q <= r_bits;
      res_len_q  <= r_len;
      res_sym_q  <= r_sym;
      res_sv_q   <= r_sv;
      res_st_q   <= r_st;
      if (kind_i == K_LOAD && int'(cnt_eff) < LEAVES) begin
        weight_q[IW'(cnt_eff)] <= w_in;
        char_q[LW'(cnt_eff)]   <= leaf_symbol_i;
      end
    end
    if (cmd_i.clear) begin
      for (int k = 0; k < NODES; k++) begin
        left_q[k]   <= '0;
        right_q[k]  <= '0;
        parent_q[k] <= '0;
        if (k >= LEAVES) weight_q[k] <= '0;
      end
      i_q    <= IW'(LEAVES);
      j_q    <= '0;
      f1_q   <= 1'b0;
      f2_q   <= 1'b0;
      leaf_q <= '0;
    end
    // one candidate node per cycle, strict less-than keeps the earliest
    if (cmd_i.scan) begin
      j_q <= j_q + IW'(1);
      if (jfree) begin
        if (!f1_q || jw < s1_q) begin
          s2_q <= s1_q;
          p2_q <= p1_q;
          f2_q <= f1_q;
          s1_q <= jw;
          p1_q <= j_q;
          f1_q <= 1'b1;
        end else if (!f2_q || jw < s2_q) begin
          s2_q <= jw;
          p2_q <= j_q;
          f2_q <= 1'b1;
        end
      end
    end
    if (cmd_i.merge) begin
      parent_q[p1_q] <= NW'(i_q) + NW'(1);
      parent_q[p2_q] <= NW'(i_q) + NW'(1);
      left_q[i_q]    <= NW'(p1_q) + NW'(1);
      right_q[i_q]   <= NW'(p2_q) + NW'(1);
      weight_q[i_q]  <= weight_q[p1_q] + weight_q[p2_q];
      i_q  <= i_q + IW'(1);
      j_q  <= '0;
      f1_q <= 1'b0;
      f2_q <= 1'b0;
    end
    if (cmd_i.code_init) begin
      cc_q   <= NW'(leaf_q) + NW'(1);
      cp_q   <= parent_q[IW'(leaf_q)];
      len_q  <= '0;
      bits_q <= '0;
    end
    // one level up the tree per cycle
    if (cmd_i.code_step) begin
      if (left_q[cpi] != cc_q && len_q < WLEN_W'(CBITS_W)) begin
        bits_q[len_q[CLEN_W-1:0]] <= 1'b1;
      end
      len_q <= len_q + WLEN_W'(1);
      cc_q  <= cp_q;
      cp_q  <= parent_q[cpi];
    end
    if (cmd_i.code_store) begin
      code_q[leaf_q] <= bits_q;
      clen_q[leaf_q] <= len_q[CLEN_W-1:0];
      leaf_q         <= leaf_q + LW'(1);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_bits_o      = res_bits_q;
  assign code_length_o    = res_len_q;
  assign decoded_symbol_o = res_sym_q;
  assign symbol_valid_o   = res_sv_q;
  assign status_o         = res_st_q;

endmodule

// ===== rtl/hft_chk.sv =====
// port-level checks for the huffman tree codec
module hft_chk import hft_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic [KIND_W-1:0]   kind_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [CBITS_W-1:0]  code_bits_i,
  input logic [CLEN_W-1:0]   code_length_i,
  input logic [SYM_W-1:0]    decoded_symbol_i,
  input logic                symbol_valid_i,
  input logic [STATUS_W-1:0] status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_item_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after an item");

  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && kind_i == K_LOAD |=>
      code_bits_i == '0 && code_length_i == '0 && decoded_symbol_i == '0 &&
      !symbol_valid_i && status_i == ST_OK)
    else $error("load result not all zero");

  a_no_tree_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_NO_TREE |->
      code_bits_i == '0 && code_length_i == '0 && !symbol_valid_i)
    else $error("fields set on an unbuilt tree");

  a_sym_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && symbol_valid_i |-> status_i == ST_OK && code_length_i == '0)
    else $error("decoded symbol with bad status");

endmodule

bind huffman_tree_codec_top hft_chk u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .kind_i           (in_i.kind),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .code_bits_i      (out_o.code_bits),
  .code_length_i    (out_o.code_length),
  .decoded_symbol_i (out_o.decoded_symbol),
  .symbol_valid_i   (out_o.symbol_valid),
  .status_i         (out_o.status)
);
